// ===== rtl/sdbd_pkg.sv =====
// shared constants and types of the same-direction burst detector
`default_nettype none

package sdbd_pkg;

    localparam int RING_DEPTH = 128;
    localparam int TIME_BITS  = 48;

    localparam int TIME_W  = 48;
    localparam int PRICE_W = 32;
    localparam int REQ_W   = 7;
    localparam int WIN_W   = 24;
    localparam int COUNT_W = 8;
    localparam int KIND_W  = 2;
    localparam int CFG_IDX_W = 2;

    localparam int RING_W = (TIME_BITS < TIME_W) ? TIME_BITS : TIME_W;
    localparam int HEAD_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int FILL_W = HEAD_W + 1;

    localparam logic [KIND_W-1:0] KIND_ASK   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BID   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TRADE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_OTHER = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_TRADES_REQUIRED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_US       = 2'd1;

    localparam logic [REQ_W-1:0] REQ_RESET = 7'd3;
    localparam logic [WIN_W-1:0] WIN_RESET = 24'd1000000;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } t_dir;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_CHECK = 3'b010,
        ST_EMIT  = 3'b100
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/same_direction_burst_detector_unit.sv =====
// same-direction burst detector: streak ring of trade timestamps with window expiry
// operation: a record is taken in idle, expired entries are dropped from the ring front in the
//   check state (run only when two or more entries remain), then the result is registered in emit
// flow: one record at a time, taken in idle only; a result waiting in the output register keeps
//   the block in the emit state and so holds back the next input as well
// reset: synchronous active low; clears state and handshakes, restores default settings
`default_nettype none

module same_direction_burst_detector_unit
    import sdbd_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // input stream
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [79:0]            s_axis_tdata,  // trade_price[31:0], time_us[79:32]
    input  wire logic [KIND_W-1:0]      s_axis_tuser,  // record_kind[1:0]
    // result stream
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [39:0]                 m_axis_tdata,  // alert_price[31:0], streak_count[39:32]
    output logic [1:0]                  m_axis_tuser,  // alert[0], alert_up[1]
    // configuration writes
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [WIN_W-1:0]       i_cfg_data
);

    // wrap-around increment of a ring pointer
    function automatic logic [HEAD_W-1:0] ring_next(input logic [HEAD_W-1:0] idx);
        logic [HEAD_W-1:0] res;
        if (idx == HEAD_W'(RING_DEPTH - 1)) begin
            res = '0;
        end else begin
            res = idx + 1'b1;
        end
        return res;
    endfunction

    // configuration registers
    logic [REQ_W-1:0]   r_req;
    logic [WIN_W-1:0]   r_win;

    // block state
    t_state             r_state, n_state;
    t_dir               r_dir, n_dir;
    logic [PRICE_W-1:0] r_last_price, n_last_price;
    logic [HEAD_W-1:0]  r_head, n_head;
    logic [FILL_W-1:0]  r_fill, n_fill;

    // record under work
    logic [RING_W-1:0]  r_now;
    logic [PRICE_W-1:0] r_price;
    logic               r_push, n_push;

    // output register
    logic               r_m_valid;
    logic [1:0]         r_m_user;
    logic [39:0]        r_m_data;

    // input field split
    logic [KIND_W-1:0]  in_kind;
    logic [PRICE_W-1:0] in_price;
    logic [RING_W-1:0]  in_now;

    assign in_kind  = s_axis_tuser;
    assign in_price = s_axis_tdata[PRICE_W-1:0];
    assign in_now   = s_axis_tdata[PRICE_W +: RING_W];

    // ring memory signals
    logic               ram_wr_en;
    logic [HEAD_W-1:0]  ram_wr_addr;
    logic [RING_W-1:0]  ram_rd_data;

    sdbd_ram #(
        .WIDTH (RING_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (in_now),
        .i_rd_addr (n_head),
        .o_rd_data (ram_rd_data)
    );

    // direction of the incoming record
    t_dir               in_dir;
    logic               in_take;

    always_comb begin
        in_dir = DIR_NONE;
        case (in_kind)
            KIND_ASK: in_dir = DIR_UP;
            KIND_BID: in_dir = DIR_DOWN;
            KIND_TRADE: begin
                // unknown last price or equal price gives no direction
                if (r_last_price != '0) begin
                    if (in_price > r_last_price) begin
                        in_dir = DIR_UP;
                    end else if (in_price < r_last_price) begin
                        in_dir = DIR_DOWN;
                    end
                end
            end
            default: in_dir = DIR_NONE;
        endcase
    end

    assign in_take = s_axis_tvalid && s_axis_tready;

    // push position and front expiry test
    logic [FILL_W-1:0]  fill_base;
    logic [HEAD_W:0]    pos_sum;
    logic [HEAD_W-1:0]  push_pos;
    logic [RING_W-1:0]  age;
    logic               front_expired;

    always_comb begin
        // direction change empties the streak
        fill_base = (in_dir != r_dir) ? '0 : r_fill;
        pos_sum   = {1'b0, r_head} + fill_base[HEAD_W:0];
        if (pos_sum >= (HEAD_W + 1)'(RING_DEPTH)) begin
            pos_sum = pos_sum - (HEAD_W + 1)'(RING_DEPTH);
        end
        push_pos = pos_sum[HEAD_W-1:0];
    end

    // front is dropped only when it is older than the window; newer entries stay
    assign age           = r_now - ram_rd_data;
    assign front_expired = (r_now >= ram_rd_data)
                        && (age > {{(RING_W - WIN_W){1'b0}}, r_win});

    // result fields from the state after the record
    logic [FILL_W+7:0]  fill_ext;
    logic [COUNT_W-1:0] res_count;
    logic               res_alert;

    assign fill_ext  = {8'b0, r_fill};
    assign res_count = (fill_ext > (FILL_W + 8)'(255)) ? 8'hFF : fill_ext[COUNT_W-1:0];
    assign res_alert = r_push && (fill_ext == {{(FILL_W + 1){1'b0}}, r_req});

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_dir        = r_dir;
        n_last_price = r_last_price;
        n_head       = r_head;
        n_fill       = r_fill;
        n_push       = r_push;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = push_pos;

        case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    n_push  = 1'b0;
                    n_state = ST_EMIT;
                    if (in_kind != KIND_OTHER) begin
                        n_last_price = in_price;
                    end
                    if (in_kind != KIND_OTHER && in_dir != DIR_NONE) begin
                        n_push    = 1'b1;
                        n_dir     = in_dir;
                        ram_wr_en = 1'b1;
                        if (fill_base == FILL_W'(RING_DEPTH)) begin
                            // full ring: overwrite the oldest entry
                            ram_wr_addr = r_head;
                            n_head      = ring_next(r_head);
                            n_fill      = FILL_W'(RING_DEPTH);
                        end else begin
                            n_fill = fill_base + 1'b1;
                        end
                        // the newest entry never expires, so a lone entry needs no check
                        if (n_fill > FILL_W'(1)) begin
                            n_state = ST_CHECK;
                        end
                    end
                end
            end
            ST_CHECK: begin
                // front entry of r_head is on the read port
                if (front_expired) begin
                    n_head = ring_next(r_head);
                    n_fill = r_fill - 1'b1;
                    if (n_fill == FILL_W'(1)) begin
                        n_state = ST_EMIT;
                    end
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_dir        <= DIR_NONE;
            r_last_price <= '0;
            r_head       <= '0;
            r_fill       <= '0;
            r_push       <= 1'b0;
            r_m_valid    <= 1'b0;
            r_req        <= REQ_RESET;
            r_win        <= WIN_RESET;
        end else begin
            r_state      <= n_state;
            r_dir        <= n_dir;
            r_last_price <= n_last_price;
            r_head       <= n_head;
            r_fill       <= n_fill;
            r_push       <= n_push;
            if (r_state == ST_EMIT && (!r_m_valid || m_axis_tready)) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_TRADES_REQUIRED: r_req <= i_cfg_data[REQ_W-1:0];
                    CFG_WINDOW_US:       r_win <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_now   <= in_now;
            r_price <= in_price;
        end
        if (r_state == ST_EMIT && (!r_m_valid || m_axis_tready)) begin
            r_m_user <= {res_alert && (r_dir == DIR_UP), res_alert};
            r_m_data <= {res_count, res_alert ? r_price : {PRICE_W{1'b0}}};
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_user;
    assign m_axis_tdata  = r_m_data;
    assign o_cfg_ready   = 1'b1;

endmodule

`default_nettype wire

// ===== rtl/sdbd_ram.sv =====
// generic simple dual-port ram with registered read
`default_nettype none

module sdbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

// ===== tb/same_direction_burst_detector_unit_tb.sv =====
// testbench for the same-direction burst detector: directed table, random streaks, scoreboard

module same_direction_burst_detector_unit_tb;
    import sdbd_pkg::*;

    localparam int STALL_LIMIT = 4000;  // cycles with no transfer anywhere before giving up

    typedef struct packed {
        logic               flag;
        logic               rising;
        logic [PRICE_W-1:0] price;
        logic [COUNT_W-1:0] count;
    } t_burst_result;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [PRICE_W-1:0] price;
        logic [TIME_W-1:0]  stamp;
        logic               typed;   // expectation below is used instead of the predictor
        t_burst_result      want;
    } t_script_row;

    // clock and block ports, all inputs known from time zero
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [79:0]          s_axis_tdata = '0;  // trade_price[31:0], time_us[79:32]
    logic [KIND_W-1:0]    s_axis_tuser = '0;  // record_kind[1:0]
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b1;
    logic [39:0]          m_axis_tdata;       // alert_price[31:0], streak_count[39:32]
    logic [1:0]           m_axis_tuser;       // alert[0], alert_up[1]
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [WIN_W-1:0]     i_cfg_data = '0;

    same_direction_burst_detector_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor state, mirrors the block after reset
    logic [REQ_W-1:0]   req_cfg = REQ_RESET;
    logic [WIN_W-1:0]   win_cfg = WIN_RESET;
    logic [PRICE_W-1:0] last_px = '0;
    t_dir               run_dir = DIR_NONE;
    logic [TIME_W-1:0]  stamp_ring [RING_DEPTH];
    logic [HEAD_W-1:0]  streak_head = '0;
    logic [FILL_W-1:0]  streak_fill = '0;

    t_burst_result pending_results [$];

    // stimulus state and run statistics
    logic [TIME_W-1:0]  stim_time = 48'd5000000;
    logic [PRICE_W-1:0] stim_price = 32'd100000;
    logic               no_gaps = 1'b0;
    int                 ready_hold = 0;
    int                 idle_cycles = 0;
    int                 errors = 0;
    int                 records_sent = 0;
    int                 reg_writes = 0;
    int                 results_seen = 0;
    int                 alerts_seen = 0;
    int                 full_ring_seen = 0;

    t_script_row script [15] = '{
        // other record on an empty block: nothing happens
        '{KIND_OTHER, 32'hFFFF_FFFF, 48'd0,       1'b1, '{1'b0, 1'b0, 32'd0, 8'd0}},
        // unclassified trade with unknown last price only stores the price
        '{KIND_TRADE, 32'd100,       48'd10,      1'b1, '{1'b0, 1'b0, 32'd0, 8'd0}},
        // same price again leaves the streak empty
        '{KIND_TRADE, 32'd100,       48'd20,      1'b1, '{1'b0, 1'b0, 32'd0, 8'd0}},
        '{KIND_TRADE, 32'd101,       48'd30,      1'b0, '0},
        // ask at zero price still counts
        '{KIND_ASK,   32'd0,         48'd40,      1'b0, '0},
        // third up entry hits the reset requirement at the top price
        '{KIND_ASK,   32'hFFFF_FFFF, 48'd50,      1'b1, '{1'b1, 1'b1, 32'hFFFF_FFFF, 8'd3}},
        '{KIND_BID,   32'd0,         48'd60,      1'b0, '0},
        '{KIND_TRADE, 32'd5,         48'd70,      1'b0, '0},
        '{KIND_TRADE, 32'd3,         48'd80,      1'b0, '0},
        // one entry just outside the window, one exactly on its edge
        '{KIND_BID,   32'd7,         48'd1000080, 1'b0, '0},
        '{KIND_OTHER, 32'd0,         48'd1000080, 1'b0, '0},
        // time going backwards keeps newer entries
        '{KIND_BID,   32'd9,         48'd50,      1'b0, '0},
        '{KIND_ASK,   32'd1,         48'hFFFF_FFFF_FFFF, 1'b0, '0},
        '{KIND_ASK,   32'd2,         48'd0,       1'b0, '0},
        '{KIND_ASK,   32'hFFFF_FFFE, 48'hFFFF_FFFF_FFFF, 1'b0, '0}
    };

    function automatic logic [HEAD_W-1:0] next_slot(input logic [HEAD_W-1:0] slot);
        return (int'(slot) + 1 >= RING_DEPTH) ? '0 : slot + 1'b1;
    endfunction

    // one record through the streak logic: direction, push, window expiry, alert
    function automatic t_burst_result predict_burst(input logic [KIND_W-1:0] kind,
                                                    input logic [PRICE_W-1:0] price,
                                                    input logic [TIME_W-1:0] now);
        t_burst_result     res;
        t_dir              dir;
        int                slot;
        logic [TIME_W-1:0] front;
        res = '0;
        dir = DIR_NONE;
        if (kind == KIND_ASK) begin
            dir = DIR_UP;
        end else if (kind == KIND_BID) begin
            dir = DIR_DOWN;
        end else if (kind == KIND_TRADE && last_px != '0) begin
            if (price > last_px) dir = DIR_UP;
            else if (price < last_px) dir = DIR_DOWN;
        end
        if (dir != DIR_NONE) begin
            // a turn empties the streak
            if (dir != run_dir) begin
                run_dir = dir;
                streak_fill = '0;
            end
            if (int'(streak_fill) >= RING_DEPTH) begin
                stamp_ring[streak_head] = now;
                streak_head = next_slot(streak_head);
            end else begin
                slot = int'(streak_head) + int'(streak_fill);
                if (slot >= RING_DEPTH) slot -= RING_DEPTH;
                stamp_ring[slot] = now;
                streak_fill = streak_fill + 1'b1;
            end
            while (streak_fill != '0) begin
                front = stamp_ring[streak_head];
                if (now < front || now - front <= TIME_W'(win_cfg)) break;
                streak_head = next_slot(streak_head);
                streak_fill = streak_fill - 1'b1;
            end
            res.flag   = (streak_fill == FILL_W'(req_cfg));
            res.rising = res.flag && dir == DIR_UP;
            res.price  = res.flag ? price : '0;
        end
        if (kind != KIND_OTHER) last_px = price;
        res.count = COUNT_W'(streak_fill);
        return res;
    endfunction

    // mostly back to back, some short pauses, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_record(input logic [KIND_W-1:0] kind, input logic [PRICE_W-1:0] price,
                               input logic [TIME_W-1:0] stamp, input logic typed,
                               input t_burst_result want);
        t_burst_result predicted;
        int            gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {stamp, price};
        s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!s_axis_tready);
        // transfer taken: the predictor advances with the block
        predicted = predict_burst(kind, price, stamp);
        pending_results.insert(pending_results.size(), typed ? want : predicted);
        records_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WIN_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_TRADES_REQUIRED) req_cfg = value[REQ_W-1:0];
        else if (idx == CFG_WINDOW_US) win_cfg = value;
        reg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // sender holds off until every outstanding result has been seen
    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // streaks of one direction with random content, broken up by noise records
    task automatic run_phase(input int n_records, input int max_burst);
        int                 done;
        int                 burst_len;
        int                 r;
        logic               up;
        logic               clean;
        logic [KIND_W-1:0]  kind;
        logic [PRICE_W-1:0] price;
        logic [TIME_W-1:0]  scale;
        done  = 0;
        // small steps keep a full requirement inside the window
        scale = TIME_W'(win_cfg) / (TIME_W'(req_cfg) * 2 + 1) + 1;
        while (done < n_records) begin
            burst_len = $urandom_range(1, max_burst);
            if (burst_len > n_records - done) burst_len = n_records - done;
            up        = 1'($urandom_range(0, 1));
            clean     = max_burst > 20 && $urandom_range(0, 1) == 1;
            no_gaps   = $urandom_range(0, 7) == 0;
            repeat (burst_len) begin
                r     = clean ? $urandom_range(0, 77) : $urandom_range(0, 99);
                price = up ? stim_price + $urandom_range(1, 40)
                           : stim_price - $urandom_range(1, 40);
                kind  = up ? KIND_ASK : KIND_BID;
                if (r < 40) begin
                    // ask or bid in the streak direction
                end else if (r < 78) begin
                    kind = KIND_TRADE;
                end else if (r < 84) begin
                    kind  = KIND_OTHER;
                    price = $urandom;
                end else if (r < 89) begin
                    kind  = KIND_TRADE;
                    price = stim_price;
                end else if (r < 93) begin
                    price = '0;
                end else begin
                    kind  = KIND_W'($urandom_range(0, 3));
                    price = $urandom;
                end
                r = clean ? $urandom_range(0, 69) : $urandom_range(0, 99);
                if (r < 70) stim_time = stim_time + $urandom_range(0, 32'(scale));
                else if (r < 85) stim_time = stim_time + $urandom_range(0, 32'(win_cfg));
                else if (r < 94) stim_time = stim_time + win_cfg + 1 + $urandom_range(0, 32'(win_cfg));
                else if (r < 97) stim_time = stim_time - $urandom_range(1, 1000);
                else stim_time = {16'($urandom), 32'($urandom)};
                send_record(kind, price, stim_time, 1'b0, '0);
                if (kind != KIND_OTHER) begin
                    stim_price = price;
                    done++;
                end
            end
        end
    endtask

    // result side: random backpressure, none while no_gaps is set
    always @(negedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold--;
            m_axis_tready <= 1'b0;
        end else begin
            ready_hold = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
            m_axis_tready <= (ready_hold == 0);
        end
    end

    // scoreboard: every result transfer against the oldest expectation
    always @(posedge i_clk) begin
        t_burst_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (m_axis_tuser[0] === 1'b1) alerts_seen++;
            if (int'(m_axis_tdata[39:32]) == RING_DEPTH) full_ring_seen++;
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing expected");
                errors++;
            end else begin
                want = pending_results[0];
                pending_results.delete(0);
                if (m_axis_tuser[0] !== want.flag) begin
                    $error("alert: expected %0d, got %0d", want.flag, m_axis_tuser[0]);
                    errors++;
                end
                if (m_axis_tuser[1] !== want.rising) begin
                    $error("alert_up: expected %0d, got %0d", want.rising, m_axis_tuser[1]);
                    errors++;
                end
                if (m_axis_tdata[31:0] !== want.price) begin
                    $error("alert_price: expected %0d, got %0d", want.price, m_axis_tdata[31:0]);
                    errors++;
                end
                if (m_axis_tdata[39:32] !== want.count) begin
                    $error("streak_count: expected %0d, got %0d", want.count,
                           m_axis_tdata[39:32]);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [REQ_W-1:0] req;
        logic [WIN_W-1:0] win;
        int               n_records;
        int               max_burst;

        // synchronous reset, released at a falling edge
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table at the reset settings
        foreach (script[i])
            send_record(script[i].kind, script[i].price, script[i].stamp,
                        script[i].typed, script[i].want);

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin req = 7'd1;   win = 24'd50000;    n_records = 70;  max_burst = 8;   end
                1: begin req = 7'd127; win = 24'd10000000; n_records = 200; max_burst = 200; end
                2: begin req = 7'd0;   win = 24'd0;        n_records = 50;  max_burst = 6;   end
                3: begin req = 7'd100; win = 24'hFFFFFF;   n_records = 120; max_burst = 160; end
                default: begin
                    req       = REQ_W'($urandom_range(2, 8));
                    win       = WIN_W'($urandom_range(50000, 10000000));
                    n_records = 60;
                    max_burst = 12;
                end
            endcase
            // settings change only with the block idle
            drain_results();
            write_reg(CFG_TRADES_REQUIRED, WIN_W'(req));
            write_reg(CFG_WINDOW_US, win);
            run_phase(n_records, max_burst);
        end

        drain_results();
        repeat (RING_DEPTH + 8) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            errors++;
        end

        $display("run: %0d records in, %0d results checked, %0d register writes",
                 records_sent, results_seen, reg_writes);
        $display("run: %0d alerts raised, %0d results with a saturated streak ring",
                 alerts_seen, full_ring_seen);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
